// File: rtl/opfd_pkg.sv
// ----------------------------------------------------------------------------
// opfd_pkg
// Shared types, register indexes and the pulse match helper for the OOK
// pulse-width frame decoder.
// ----------------------------------------------------------------------------
package opfd_pkg;

   // Field widths
   localparam int unsigned LEN_W    = 20;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned FRAME_W  = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TIME      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BIT_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BIT_COUNT = 3'd5;

   // Register reset values
   localparam logic [TIME_W-1:0]  SHORT_TIME_RST    = 16'd250;
   localparam logic [TIME_W-1:0]  LONG_TIME_RST     = 16'd500;
   localparam logic [TIME_W-1:0]  TOLERANCE_RST     = 16'd120;
   localparam logic [LEN_W-1:0]   GAP_TIME_RST      = 20'd1500;
   localparam logic [COUNT_W-1:0] MIN_BIT_COUNT_RST = 7'd64;
   localparam logic [COUNT_W-1:0] MAX_BIT_COUNT_RST = 7'd80;

   // Frame decoder phase; code 3 is unused
   typedef enum logic [1:0] {
      PHASE_IDLE       = 2'd0,
      PHASE_WAIT_MARK  = 2'd1,
      PHASE_WAIT_SPACE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0]  short_time;
      logic [TIME_W-1:0]  long_time;
      logic [TIME_W-1:0]  tolerance;
      logic [LEN_W-1:0]   gap_time;
      logic [COUNT_W-1:0] min_bit_count;
      logic [COUNT_W-1:0] max_bit_count;
   } config_type;

   typedef struct packed {
      logic               emit;
      logic [FRAME_W-1:0] frame_bits;
      logic [COUNT_W-1:0] frame_length;
   } frame_type;

   // True when |len - nominal| < tol
   function automatic logic near_value(input logic [LEN_W-1:0]  len,
                                       input logic [TIME_W-1:0] nominal,
                                       input logic [TIME_W-1:0] tol);
      logic [LEN_W-1:0] nom_ext;
      logic [LEN_W-1:0] diff;
      nom_ext = {{(LEN_W-TIME_W){1'b0}}, nominal};
      diff    = (len > nom_ext) ? (len - nom_ext) : (nom_ext - len);
      return diff < {{(LEN_W-TIME_W){1'b0}}, tol};
   endfunction

endpackage

// File: rtl/opfd_req_if.sv
// ----------------------------------------------------------------------------
// opfd_req_if
// Pulse channel: one radio pulse (level and duration) per transaction.
// ----------------------------------------------------------------------------
interface opfd_req_if;
   logic        valid;
   logic        ready;
   logic        pulse_level;
   logic [19:0] pulse_length;

   modport source (output valid, output pulse_level, output pulse_length, input ready);
   modport sink   (input valid, input pulse_level, input pulse_length, output ready);
endinterface

// File: rtl/opfd_rsp_if.sv
// ----------------------------------------------------------------------------
// opfd_rsp_if
// Frame channel: one decoded frame and its split fields per transaction.
// ----------------------------------------------------------------------------
interface opfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] frame_bits;
   logic [6:0]  frame_length;
   logic [31:0] serial_number;
   logic [3:0]  button_code;
   logic [15:0] press_counter;

   modport source (output valid, output frame_bits, output frame_length,
                   output serial_number, output button_code, output press_counter,
                   input ready);
   modport sink   (input valid, input frame_bits, input frame_length,
                   input serial_number, input button_code, input press_counter,
                   output ready);
endinterface

// File: rtl/opfd_frame_core.sv
// ----------------------------------------------------------------------------
// opfd_frame_core
// Frame state machine: classifies one pulse per step, shifts bits into the
// frame register and reports a finished frame that passes the length check.
// ----------------------------------------------------------------------------
module opfd_frame_core
   import opfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_valid,
   input  logic               pulse_level,
   input  logic [LEN_W-1:0]   pulse_length,
   input  config_type         cfg,
   output frame_type          frame
);

   phase_type            phase_ff, phase_in;
   logic [FRAME_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 match_short;
   logic                 match_long;
   logic                 mark_ok;
   logic [FRAME_W-1:0]   shifted;
   logic [COUNT_W:0]     count_inc;
   logic                 too_many;
   logic                 length_ok;
   logic                 end_frame;

   // Classify the pulse against the configured times
   always_comb begin
      match_short = near_value(pulse_length, cfg.short_time, cfg.tolerance);
      match_long  = near_value(pulse_length, cfg.long_time, cfg.tolerance);
      mark_ok     = match_short || match_long;
      shifted     = {shift_ff[FRAME_W-2:0], ~match_short};
      count_inc   = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
      too_many    = count_inc > {1'b0, cfg.max_bit_count};
      length_ok   = (count_ff >= cfg.min_bit_count) && (count_ff <= cfg.max_bit_count);
   end

   // Next state and frame end
   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      count_in  = count_ff;
      end_frame = 1'b0;
      if (step_valid) begin
         unique case (phase_ff)
            PHASE_IDLE: begin
               if (pulse_level && mark_ok) begin
                  phase_in = PHASE_WAIT_SPACE;
                  shift_in = shifted;
                  count_in = count_inc[COUNT_W-1:0];
               end
            end
            PHASE_WAIT_SPACE: begin
               if (!pulse_level) begin
                  if (match_short) begin
                     phase_in = PHASE_WAIT_MARK;
                  end else begin
                     end_frame = 1'b1;
                  end
               end
            end
            PHASE_WAIT_MARK: begin
               if (pulse_level) begin
                  if (mark_ok) begin
                     phase_in = PHASE_WAIT_SPACE;
                     shift_in = shifted;
                     count_in = count_inc[COUNT_W-1:0];
                  end else begin
                     end_frame = 1'b1;
                  end
               end else if (pulse_length >= cfg.gap_time) begin
                  end_frame = 1'b1;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
               shift_in = '0;
               count_in = '0;
            end
         endcase
         // Drop the frame once it grows past the limit
         if ((phase_ff == PHASE_IDLE || phase_ff == PHASE_WAIT_MARK) &&
             pulse_level && mark_ok && too_many) begin
            phase_in = PHASE_IDLE;
            shift_in = '0;
            count_in = '0;
         end
         if (end_frame) begin
            phase_in = PHASE_IDLE;
            shift_in = '0;
            count_in = '0;
         end
      end
      frame.emit         = end_frame && length_ok;
      frame.frame_bits   = shift_ff;
      frame.frame_length = count_ff;
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         shift_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/ook_pwm_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// ook_pwm_frame_decoder_unit
// OOK pulse-width frame decoder: turns a stream of pulses into frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one pulse per transaction (level, duration in us).
//   rsp_ch carries one decoded frame per transaction; most pulses give none.
//   csr_we/csr_index/csr_wdata write the timing and bit count registers;
//   write them only while no pulse is in flight.
// Timing:
//   A pulse taken on req_ch sits in the input register until it is
//   decoded; its frame, if any, is then loaded into the output register.
//   One pulse per cycle is sustained while the output register is free or
//   draining: the input register, the frame state machine and the output
//   register form a two-stage pipeline with no stall of its own.
// Stall:
//   While a frame waits on rsp_ch, the next pulse still decodes if the
//   output register is being drained; otherwise the pulse is held in the
//   input register and req_ch.ready drops once that register is full.
// Reset:
//   Synchronous, active high. Clears the frame state, both pipeline stages
//   and loads the default timing registers.
// ----------------------------------------------------------------------------
module ook_pwm_frame_decoder_unit
   import opfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   opfd_req_if.sink              req_ch,
   opfd_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   config_type          cfg_ff, cfg_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_level_ff;
   logic [LEN_W-1:0]    s1_length_ff;

   logic                out_valid_ff, out_valid_in;
   logic [FRAME_W-1:0]  out_bits_ff;
   logic [COUNT_W-1:0]  out_length_ff;

   logic                req_take;
   logic                advance;
   frame_type           frame;

   // Configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SHORT_TIME:    cfg_in.short_time    = csr_wdata[TIME_W-1:0];
            CSR_LONG_TIME:     cfg_in.long_time     = csr_wdata[TIME_W-1:0];
            CSR_TOLERANCE:     cfg_in.tolerance     = csr_wdata[TIME_W-1:0];
            CSR_GAP_TIME:      cfg_in.gap_time      = csr_wdata[LEN_W-1:0];
            CSR_MIN_BIT_COUNT: cfg_in.min_bit_count = csr_wdata[COUNT_W-1:0];
            CSR_MAX_BIT_COUNT: cfg_in.max_bit_count = csr_wdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_time    <= SHORT_TIME_RST;
         cfg_ff.long_time     <= LONG_TIME_RST;
         cfg_ff.tolerance     <= TOLERANCE_RST;
         cfg_ff.gap_time      <= GAP_TIME_RST;
         cfg_ff.min_bit_count <= MIN_BIT_COUNT_RST;
         cfg_ff.max_bit_count <= MAX_BIT_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline handshake: decode when the output register is free or draining
   always_comb begin
      advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !s1_valid_ff || advance;
      req_take     = req_ch.valid && req_ch.ready;
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      if (advance) begin
         out_valid_in = frame.emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ch.ready;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_level_ff  <= req_ch.pulse_level;
         s1_length_ff <= req_ch.pulse_length;
      end
   end

   // Frame state machine
   opfd_frame_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (advance),
      .pulse_level  (s1_level_ff),
      .pulse_length (s1_length_ff),
      .cfg          (cfg_ff),
      .frame        (frame)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && frame.emit) begin
         out_bits_ff   <= frame.frame_bits;
         out_length_ff <= frame.frame_length;
      end
   end

   // Split the frame fields
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_bits    = out_bits_ff;
   assign rsp_ch.frame_length  = out_length_ff;
   assign rsp_ch.serial_number = out_bits_ff[63:32];
   assign rsp_ch.button_code   = out_bits_ff[31:28];
   assign rsp_ch.press_counter = out_bits_ff[15:0];

   // Checks
   a_new_frame_from_decode: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && frame.emit))
      else $error("frame appeared without a decoded frame end");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("pulse channel stalled with room in the pipeline");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("taken pulse lost from the input register");

   a_frame_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.frame_length != '0))
      else $error("emitted frame carries no bits");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OOK pulse-width frame decoder. A directed table
// of pulses and register writes opens the run. Randomized frames with noise
// and broken tails follow over several timing and bit count settings. Every
// frame taken from the block is compared field by field with the frame that
// the table gives or that an in-bench decoder model predicts.
// ----------------------------------------------------------------------------
module tb
   import opfd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned CHOKE_CYCLES  = 300;
   localparam int unsigned MAX_SHOWN     = 10;
   localparam logic [LEN_W-1:0] LEN_MAX  = '1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_bits;
      logic [COUNT_W-1:0] frame_length;
      logic [31:0]        serial_number;
      logic [3:0]         button_code;
      logic [15:0]        press_counter;
   } frame_rec_type;

   typedef enum {ROW_PULSE, ROW_CSR} row_kind_type;
   typedef enum {TAIL_GAP, TAIL_BAD_MARK, TAIL_BAD_SPACE, TAIL_NONE} tail_kind_type;
   typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PACED} sink_mode_type;

   typedef struct {
      row_kind_type          kind;
      logic                  level;
      logic [LEN_W-1:0]      value;
      logic [CSR_IDX_W-1:0]  index;
      bit                    typed;
      bit                    emit;
      frame_rec_type         frame;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   opfd_req_if req_ch();
   opfd_rsp_if rsp_ch();

   ook_pwm_frame_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Decoder model state and its copy of the registers
   phase_type        dec_phase;
   logic [63:0]      dec_shift;
   int unsigned      dec_count;
   int unsigned      cfg_short;
   int unsigned      cfg_long;
   int unsigned      cfg_tol;
   int unsigned      cfg_gap;
   int unsigned      cfg_min;
   int unsigned      cfg_max;

   frame_rec_type    frames_due[$];
   int unsigned      fail_count;
   int unsigned      burst_left;
   bit               choke_req;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic bit is_near(input int unsigned len, input int unsigned nominal);
      int unsigned d;
      d = (len > nominal) ? (len - nominal) : (nominal - len);
      return d < cfg_tol;
   endfunction

   function automatic void model_clear();
      dec_phase = PHASE_IDLE;
      dec_shift = '0;
      dec_count = 0;
   endfunction

   // Shift in a mark as a bit; drop the frame when the count runs over
   function automatic bit shift_mark(input logic [LEN_W-1:0] len);
      logic b;
      if (is_near(len, cfg_short))
         b = 1'b0;
      else if (is_near(len, cfg_long))
         b = 1'b1;
      else
         return 1'b0;
      dec_shift = {dec_shift[62:0], b};
      dec_phase = PHASE_WAIT_SPACE;
      if (dec_count + 1 > cfg_max || dec_count + 1 > 127)
         model_clear();
      else
         dec_count = dec_count + 1;
      return 1'b1;
   endfunction

   // Close the frame; hand it out only when its length is in range
   function automatic bit close_frame(output frame_rec_type f);
      bit hit;
      f   = '0;
      hit = (dec_count >= cfg_min) && (dec_count <= cfg_max);
      if (hit) begin
         f.frame_bits    = dec_shift;
         f.frame_length  = 7'(dec_count);
         f.serial_number = dec_shift[63:32];
         f.button_code   = dec_shift[31:28];
         f.press_counter = dec_shift[15:0];
      end
      model_clear();
      return hit;
   endfunction

   // Advance the model by one pulse; return 1 when a frame comes out
   function automatic bit decode_pulse(input logic lvl, input logic [LEN_W-1:0] len,
                                       output frame_rec_type f);
      f = '0;
      case (dec_phase)
         PHASE_IDLE: begin
            if (lvl)
               void'(shift_mark(len));
            return 1'b0;
         end
         PHASE_WAIT_SPACE: begin
            if (lvl)
               return 1'b0;
            if (is_near(len, cfg_short)) begin
               dec_phase = PHASE_WAIT_MARK;
               return 1'b0;
            end
            return close_frame(f);
         end
         PHASE_WAIT_MARK: begin
            if (lvl) begin
               if (shift_mark(len))
                  return 1'b0;
               return close_frame(f);
            end
            if (len >= cfg_gap)
               return close_frame(f);
            return 1'b0;
         end
         default: begin
            model_clear();
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void model_reset();
      cfg_short = SHORT_TIME_RST;
      cfg_long  = LONG_TIME_RST;
      cfg_tol   = TOLERANCE_RST;
      cfg_gap   = GAP_TIME_RST;
      cfg_min   = MIN_BIT_COUNT_RST;
      cfg_max   = MAX_BIT_COUNT_RST;
      model_clear();
   endfunction

   // ------------------------------------------------------------------------
   // Pulse lengths
   // ------------------------------------------------------------------------
   function automatic logic [LEN_W-1:0] fit_len(input longint v);
      if (v < 0)
         return '0;
      if (v > longint'(LEN_MAX))
         return LEN_MAX;
      return v[LEN_W-1:0];
   endfunction

   // Pick a length that should match the nominal time
   function automatic logic [LEN_W-1:0] near_len(input int unsigned nominal);
      longint off;
      if (cfg_tol <= 1)
         return fit_len(longint'(nominal));
      off = $urandom_range(cfg_tol - 1, 0);
      if ($urandom_range(1, 0) == 1)
         off = -off;
      return fit_len(longint'(nominal) + off);
   endfunction

   // Pick a length that should miss the short time
   function automatic logic [LEN_W-1:0] far_len();
      int unsigned pick;
      pick = $urandom_range(3, 0);
      if (pick == 0)
         return LEN_MAX;
      if (pick == 1)
         return LEN_W'($urandom_range(32'hFFFFF, 0));
      if (pick == 2)
         return fit_len(longint'(cfg_long) + cfg_tol + $urandom_range(500, 0));
      return fit_len(longint'(cfg_short) + cfg_tol + $urandom_range(500, 0));
   endfunction

   // Pick a space around the gap time, on and just below the threshold too
   function automatic logic [LEN_W-1:0] gap_len();
      int unsigned pick;
      pick = $urandom_range(9, 0);
      if (pick == 0)
         return fit_len(longint'(cfg_gap));
      if (pick == 1 && cfg_gap > 0)
         return fit_len(longint'(cfg_gap) - 1);
      return fit_len(longint'(cfg_gap) + $urandom_range(300, 0));
   endfunction

   // ------------------------------------------------------------------------
   // Pulse sender
   // ------------------------------------------------------------------------
   // Offer one pulse transaction in bursts; predict its frame on acceptance
   task automatic offer_pulse(input logic lvl, input logic [LEN_W-1:0] len,
                              input bit typed, input bit typed_emit,
                              input frame_rec_type typed_frame);
      int unsigned   idle_gap;
      bit            emit;
      frame_rec_type f;
      if (burst_left == 0) begin
         burst_left = $urandom_range(30, 1);
         if ($urandom_range(19, 0) == 0)
            idle_gap = 40;
         else if ($urandom_range(3, 0) == 0)
            idle_gap = 0;
         else
            idle_gap = $urandom_range(8, 1);
         if (idle_gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (idle_gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.pulse_level  <= lvl;
      req_ch.pulse_length <= len;
      do @(posedge clock); while (!req_ch.ready);
      emit = decode_pulse(lvl, len, f);
      if (typed) begin
         emit = typed_emit;
         f    = typed_frame;
      end
      if (emit)
         frames_due.push_back(f);
   endtask

   task automatic send(input logic lvl, input logic [LEN_W-1:0] len);
      offer_pulse(lvl, len, 1'b0, 1'b0, '0);
   endtask

   task automatic send_noise();
      int unsigned pick;
      logic        lvl;
      pick = $urandom_range(3, 0);
      lvl  = 1'($urandom_range(1, 0));
      if (pick == 0)
         send(lvl, '0);
      else if (pick == 1)
         send(lvl, LEN_MAX);
      else if (pick == 2)
         send(lvl, LEN_W'($urandom_range(32'hFFFFF, 0)));
      else
         send(lvl, near_len(($urandom_range(1, 0) == 1) ? cfg_long : cfg_short));
   endtask

   // Drop valid and wait until every frame has come out and the pipe is empty
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SHORT_TIME:    cfg_short = data[TIME_W-1:0];
         CSR_LONG_TIME:     cfg_long  = data[TIME_W-1:0];
         CSR_TOLERANCE:     cfg_tol   = data[TIME_W-1:0];
         CSR_GAP_TIME:      cfg_gap   = data[LEN_W-1:0];
         CSR_MIN_BIT_COUNT: cfg_min   = data[COUNT_W-1:0];
         CSR_MAX_BIT_COUNT: cfg_max   = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Mostly well-formed frames of random content, with noise and broken tails
   task automatic feed_random(input int unsigned budget);
      int unsigned   sent;
      int unsigned   nbits;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   i;
      tail_kind_type tail;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9, 0) < 2) begin
            send_noise();
            sent++;
         end else begin
            lo    = (cfg_min > 3) ? cfg_min - 2 : 1;
            hi    = cfg_max + 2;
            nbits = $urandom_range(hi, lo);
            for (i = 0; i < nbits; i++) begin
               send(1'b1, near_len(($urandom_range(1, 0) == 1) ? cfg_long : cfg_short));
               sent++;
               if ($urandom_range(24, 0) == 0) begin
                  send_noise();
                  sent++;
               end
               if (i + 1 < nbits) begin
                  send(1'b0, near_len(cfg_short));
                  sent++;
                  // short stray space while waiting for the next mark
                  if (cfg_gap > 0 && $urandom_range(9, 0) == 0) begin
                     send(1'b0, LEN_W'($urandom_range(cfg_gap - 1, 0)));
                     sent++;
                  end
               end
            end
            tail = tail_kind_type'($urandom_range(3, 0));
            case (tail)
               TAIL_GAP: begin
                  send(1'b0, near_len(cfg_short));
                  send(1'b0, gap_len());
                  sent += 2;
               end
               TAIL_BAD_MARK: begin
                  send(1'b0, near_len(cfg_short));
                  send(1'b1, far_len());
                  sent += 2;
               end
               TAIL_BAD_SPACE: begin
                  send(1'b0, far_len());
                  sent++;
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic run_phase(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] l,
                            input logic [TIME_W-1:0] t, input logic [LEN_W-1:0] g,
                            input logic [COUNT_W-1:0] mn, input logic [COUNT_W-1:0] mx,
                            input int unsigned budget, input bit choke);
      quiesce();
      program_reg(CSR_SHORT_TIME, CSR_DATA_W'(s));
      program_reg(CSR_LONG_TIME, CSR_DATA_W'(l));
      program_reg(CSR_TOLERANCE, CSR_DATA_W'(t));
      program_reg(CSR_GAP_TIME, g);
      program_reg(CSR_MIN_BIT_COUNT, CSR_DATA_W'(mn));
      program_reg(CSR_MAX_BIT_COUNT, CSR_DATA_W'(mx));
      if (choke)
         choke_req = 1'b1;
      feed_random(budget);
   endtask

   // ------------------------------------------------------------------------
   // Directed table rows
   // ------------------------------------------------------------------------
   function automatic plan_row_type row_pulse(input logic lvl, input logic [LEN_W-1:0] len);
      plan_row_type r;
      r.kind  = ROW_PULSE;
      r.level = lvl;
      r.value = len;
      r.index = CSR_SHORT_TIME;
      r.typed = 1'b0;
      r.emit  = 1'b0;
      r.frame = '0;
      return r;
   endfunction

   function automatic plan_row_type row_quiet(input logic lvl, input logic [LEN_W-1:0] len);
      plan_row_type r;
      r       = row_pulse(lvl, len);
      r.typed = 1'b1;
      return r;
   endfunction

   function automatic plan_row_type row_frame(input logic lvl, input logic [LEN_W-1:0] len,
                                              input logic [63:0] fb, input logic [6:0] fl,
                                              input logic [31:0] sn, input logic [3:0] bc,
                                              input logic [15:0] pc);
      plan_row_type r;
      r       = row_quiet(lvl, len);
      r.emit  = 1'b1;
      r.frame = '{fb, fl, sn, bc, pc};
      return r;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r       = row_pulse(1'b0, data);
      r.kind  = ROW_CSR;
      r.index = idx;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Frame receiver: stall on a pattern of its own, with one long hold-off
   // ------------------------------------------------------------------------
   initial begin : frame_sink
      int unsigned   seg_left;
      int unsigned   hold_left;
      sink_mode_type mode;
      seg_left  = 0;
      hold_left = 0;
      mode      = SINK_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (choke_req) begin
            hold_left = CHOKE_CYCLES;
            choke_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode     = sink_mode_type'($urandom_range(3, 0));
               seg_left = $urandom_range(60, 4);
            end
            seg_left--;
            case (mode)
               SINK_OPEN:   rsp_ch.ready <= 1'b1;
               SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(1, 0));
               SINK_MOSTLY: rsp_ch.ready <= ($urandom_range(9, 0) != 0);
               default:     rsp_ch.ready <= (seg_left % 3 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Frame checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : frame_check
      frame_rec_type got;
      frame_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.frame_bits, rsp_ch.frame_length, rsp_ch.serial_number,
                 rsp_ch.button_code, rsp_ch.press_counter};
         if (frames_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t: frame with none expected: bits=%h len=%0d",
                        $realtime, got.frame_bits, got.frame_length);
         end else begin
            want = frames_due.pop_front();
            if (got.frame_bits !== want.frame_bits ||
                got.frame_length !== want.frame_length ||
                got.serial_number !== want.serial_number ||
                got.button_code !== want.button_code ||
                got.press_counter !== want.press_counter) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display({"%0t: frame mismatch: exp bits=%h len=%0d ser=%h btn=%h cnt=%h",
                            " / got bits=%h len=%0d ser=%h btn=%h cnt=%h"}, $realtime,
                           want.frame_bits, want.frame_length, want.serial_number,
                           want.button_code, want.press_counter,
                           got.frame_bits, got.frame_length, got.serial_number,
                           got.button_code, got.press_counter);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type plan[$];
      int unsigned  s;
      fail_count = 0;
      burst_left = 0;
      choke_req  = 1'b0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_SHORT_TIME;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.pulse_level  <= 1'b0;
      req_ch.pulse_length <= '0;
      model_reset();

      // Hold reset, then release it at a falling clock edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default timing: ignored pulses, then a frame far too short to emit
      plan.push_back(row_quiet(1'b0, '0));
      plan.push_back(row_quiet(1'b1, LEN_MAX));
      plan.push_back(row_quiet(1'b1, 20'd250));
      plan.push_back(row_quiet(1'b0, LEN_MAX));
      // Accept frames of one to three bits
      plan.push_back(row_csr(CSR_MIN_BIT_COUNT, 20'd1));
      plan.push_back(row_csr(CSR_MAX_BIT_COUNT, 20'd3));
      // Tolerance edges, ignored mark and short space, frame closed by a gap
      plan.push_back(row_pulse(1'b1, 20'd130));
      plan.push_back(row_pulse(1'b1, 20'd131));
      plan.push_back(row_pulse(1'b1, 20'd500));
      plan.push_back(row_pulse(1'b0, 20'd369));
      plan.push_back(row_pulse(1'b0, 20'd1499));
      plan.push_back(row_pulse(1'b1, 20'd619));
      plan.push_back(row_pulse(1'b0, 20'd250));
      plan.push_back(row_frame(1'b0, 20'd1500, 64'h1, 7'd2, 32'h0, 4'h0, 16'h1));
      // One bit too many drops the frame
      plan.push_back(row_pulse(1'b1, 20'd500));
      plan.push_back(row_pulse(1'b0, 20'd250));
      plan.push_back(row_pulse(1'b1, 20'd250));
      plan.push_back(row_pulse(1'b0, 20'd250));
      plan.push_back(row_pulse(1'b1, 20'd500));
      plan.push_back(row_pulse(1'b0, 20'd250));
      plan.push_back(row_pulse(1'b1, 20'd500));
      plan.push_back(row_pulse(1'b0, 20'd250));
      // Wide tolerance: mark matching both times is a zero; bad mark, bad space
      plan.push_back(row_csr(CSR_TOLERANCE, 20'd200));
      plan.push_back(row_pulse(1'b1, 20'd375));
      plan.push_back(row_pulse(1'b0, 20'd250));
      plan.push_back(row_frame(1'b1, LEN_MAX, 64'h0, 7'd1, 32'h0, 4'h0, 16'h0));
      plan.push_back(row_pulse(1'b1, 20'd699));
      plan.push_back(row_frame(1'b0, 20'd600, 64'h1, 7'd1, 32'h0, 4'h0, 16'h1));

      // Walk the table
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR) begin
            quiesce();
            program_reg(plan[k].index, plan[k].value);
         end else begin
            offer_pulse(plan[k].level, plan[k].value, plan[k].typed, plan[k].emit,
                        plan[k].frame);
         end
      end

      // Long frames past 64 bits
      run_phase(16'd250, 16'd500, 16'd120, 20'd1500, 7'd47, 7'd70, 350, 1'b0);
      // Short frames, frequent results, one long receiver hold-off
      run_phase(16'd100, 16'd300, 16'd50, 20'd1000, 7'd1, 7'd4, 200, 1'b1);
      // Random timing and bit counts
      repeat (2) begin
         s = $urandom_range(3000, 20);
         run_phase(TIME_W'(s), TIME_W'(s + $urandom_range(3000, 1)),
                   TIME_W'($urandom_range(400, 1)), LEN_W'($urandom_range(20000, 0)),
                   COUNT_W'($urandom_range(20, 1)), COUNT_W'($urandom_range(24, 1)),
                   150, 1'b0);
      end
      // Register extremes: widest match, single-bit frames, longest gap
      run_phase(16'd0, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 7'd1, 7'd1, 80, 1'b0);
      // Minimum above maximum, exact match only, zero gap
      run_phase(16'hFFFF, 16'd0, 16'd1, 20'd0, 7'd80, 7'd63, 80, 1'b0);
      // Zero tolerance: nothing matches
      run_phase(16'd250, 16'd500, 16'd0, 20'd1500, 7'd1, 7'd80, 40, 1'b0);

      // Drain and report
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/opfd_pkg.sv
rtl/opfd_req_if.sv
rtl/opfd_rsp_if.sv
rtl/opfd_frame_core.sv
rtl/ook_pwm_frame_decoder_unit.sv
tb/tb.sv
